// ===== design/uasp_pkg.sv =====
`default_nettype none

package uasp_pkg;

  localparam int MAX_STREAMS_DEF = 8;
  localparam int QUEUE_DEPTH_DEF = 4;

  // Descriptor bytes kept for field capture: offsets two through ten.
  localparam int FIELD_LO = 2;
  localparam int FIELD_HI = 10;

  localparam logic [7:0] TYPE_INTERFACE     = 8'h04;
  localparam logic [7:0] TYPE_ENDPOINT      = 8'h05;
  localparam logic [7:0] TYPE_CS_INTERFACE  = 8'h24;
  localparam logic [7:0] CLASS_AUDIO        = 8'h01;
  localparam logic [7:0] SUBCLASS_STREAMING = 8'h02;
  localparam logic [7:0] SUBTYPE_FORMAT     = 8'h02;
  localparam logic [7:0] MIN_DESC_LEN       = 8'd2;
  localparam logic [7:0] FORMAT_MIN_LEN     = 8'd8;
  localparam logic [7:0] RATE_MIN_LEN       = 8'd11;
  localparam logic [7:0] ONE_DISCRETE_RATE  = 8'd1;
  localparam logic [1:0] EP_XFER_ISO        = 2'b01;

  localparam logic RECORD_STREAM  = 1'b0;
  localparam logic RECORD_SUMMARY = 1'b1;

  // Bit positions of the back-end operations carried by one event.
  localparam int OP_FIN   = 0;
  localparam int OP_CLOSE = 1;
  localparam int OP_SUM   = 2;
  localparam int N_OPS    = 3;

  typedef struct packed {
    logic [N_OPS-1:0] ops;
    logic             halted;
    logic             is_iface;
    logic             iface_match;
    logic             is_fmt;
    logic             has_rate;
    logic             is_ep;
    logic [7:0]       val_a;
    logic [7:0]       val_b;
    logic [23:0]      rate;
    logic [10:0]      packet;
  } uasp_evt_t;

  typedef struct packed {
    logic push;
    logic full;
  } uasp_qwr_t;

  typedef struct packed {
    logic head_valid;
    logic pop;
  } uasp_qrd_t;

endpackage

`default_nettype wire

// ===== design/uasp_ifs.sv =====
`default_nettype none

interface uasp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_value;
  logic       last_byte;
  modport source(output valid, byte_value, last_byte, input ready);
  modport sink(input valid, byte_value, last_byte, output ready);
endinterface

interface uasp_out_if;
  logic        valid;
  logic        ready;
  logic        record_kind;
  logic [2:0]  stream_index;
  logic [7:0]  alt_setting;
  logic [7:0]  channel_count;
  logic [7:0]  sample_bits;
  logic [23:0] sample_rate;
  logic [7:0]  endpoint_address;
  logic [10:0] max_packet;
  logic [7:0]  poll_interval;
  logic [3:0]  stream_total;
  logic        malformed_seen;
  logic        last_result;
  modport source(output valid, record_kind, stream_index, alt_setting, channel_count,
                 sample_bits, sample_rate, endpoint_address, max_packet, poll_interval,
                 stream_total, malformed_seen, last_result, input ready);
  modport sink(input valid, record_kind, stream_index, alt_setting, channel_count,
               sample_bits, sample_rate, endpoint_address, max_packet, poll_interval,
               stream_total, malformed_seen, last_result, output ready);
endinterface

interface uasp_cfg_if;
  logic       valid;
  logic       ready;
  logic [7:0] data;
  modport source(output valid, data, input ready);
  modport sink(input valid, data, output ready);
endinterface

`default_nettype wire

// ===== design/uasp_framer.sv =====
`default_nettype none

module uasp_framer (
  input  wire logic            clk,
  input  wire logic            rst_n,
  uasp_in_if.sink              in_bus,
  uasp_cfg_if.sink             cfg_bus,
  input  wire logic            q_full,
  output logic                 evt_push,
  output uasp_pkg::uasp_evt_t  evt_data
);
  import uasp_pkg::*;

  logic [7:0] target_r;
  logic [7:0] offset_r, offset_nxt;
  logic [7:0] length_r, length_nxt;
  logic [7:0] type_r, type_nxt;
  logic       halted_r, halted_nxt;
  logic [7:0] fbyte_r [FIELD_LO:FIELD_HI];
  logic [7:0] f_eff [FIELD_LO:FIELD_HI];

  logic       accept;
  logic [7:0] b;
  logic       last;
  logic [7:0] type_eff;
  logic       at_start, desc_done, short_len, trunc, halt_now, fin;

  assign in_bus.ready  = !q_full;
  assign cfg_bus.ready = 1'b1;
  assign accept        = in_bus.valid && in_bus.ready;
  assign b             = in_bus.byte_value;
  assign last          = in_bus.last_byte;

  // The byte arriving now completes the field view used to classify the descriptor.
  always_comb begin
    for (int i = FIELD_LO; i <= FIELD_HI; i++) begin
      f_eff[i] = (offset_r == 8'(i)) ? b : fbyte_r[i];
    end
  end

  assign type_eff  = (offset_r == 8'd1) ? b : type_r;
  assign at_start  = (offset_r == 8'd0);
  assign desc_done = !at_start && (({1'b0, offset_r} + 9'd1) >= {1'b0, length_r});
  assign short_len = at_start && !last && (b < MIN_DESC_LEN);
  assign trunc     = !at_start && !desc_done && last;
  assign halt_now  = !halted_r && (short_len || trunc);
  assign fin       = !halted_r && desc_done;

  always_comb begin
    evt_data               = '0;
    evt_data.ops[OP_FIN]   = fin;
    evt_data.ops[OP_CLOSE] = halt_now || last;
    evt_data.ops[OP_SUM]   = last;
    evt_data.halted        = halted_r || halt_now;
    evt_data.is_iface      = (type_eff == TYPE_INTERFACE);
    evt_data.iface_match   = (f_eff[5] == CLASS_AUDIO) && (f_eff[6] == SUBCLASS_STREAMING) &&
                             (f_eff[2] == target_r);
    evt_data.is_fmt        = (type_eff == TYPE_CS_INTERFACE) && (length_r >= FORMAT_MIN_LEN) &&
                             (f_eff[2] == SUBTYPE_FORMAT);
    evt_data.has_rate      = (f_eff[7] == ONE_DISCRETE_RATE) && (length_r >= RATE_MIN_LEN);
    evt_data.is_ep         = (type_eff == TYPE_ENDPOINT) && (f_eff[3][1:0] == EP_XFER_ISO);
    evt_data.val_a         = evt_data.is_iface ? f_eff[3] :
                             (evt_data.is_fmt ? f_eff[4] : f_eff[2]);
    evt_data.val_b         = f_eff[6];
    evt_data.rate          = {f_eff[10], f_eff[9], f_eff[8]};
    evt_data.packet        = {f_eff[5][2:0], f_eff[4]};
  end

  assign evt_push = accept && (fin || halt_now || last);

  always_comb begin
    offset_nxt = offset_r;
    length_nxt = length_r;
    type_nxt   = type_r;
    halted_nxt = halted_r;
    if (!halted_r) begin
      if (at_start) begin
        if (!last) begin
          length_nxt = b;
          type_nxt   = 8'd0;
          if (b < MIN_DESC_LEN) begin
            halted_nxt = 1'b1;
          end else begin
            offset_nxt = 8'd1;
          end
        end
      end else begin
        type_nxt = type_eff;
        if (desc_done) begin
          offset_nxt = 8'd0;
        end else begin
          offset_nxt = offset_r + 8'd1;
          if (last) begin
            halted_nxt = 1'b1;
          end
        end
      end
    end
    // The final byte returns the framer to the start of a fresh buffer.
    if (last) begin
      offset_nxt = 8'd0;
      length_nxt = 8'd0;
      type_nxt   = 8'd0;
      halted_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      target_r <= 8'd0;
      offset_r <= 8'd0;
      length_r <= 8'd0;
      type_r   <= 8'd0;
      halted_r <= 1'b0;
    end else begin
      if (cfg_bus.valid) begin
        target_r <= cfg_bus.data;
      end
      if (accept) begin
        offset_r <= offset_nxt;
        length_r <= length_nxt;
        type_r   <= type_nxt;
        halted_r <= halted_nxt;
      end
    end
  end

  // Field bytes are zeroed when a descriptor starts, so short descriptors read zero.
  always_ff @(posedge clk) begin
    if (accept && !halted_r) begin
      for (int i = FIELD_LO; i <= FIELD_HI; i++) begin
        if (at_start) begin
          if (!last) begin
            fbyte_r[i] <= 8'd0;
          end
        end else begin
          fbyte_r[i] <= f_eff[i];
        end
      end
    end
  end

endmodule

`default_nettype wire

// ===== design/uasp_evtq.sv =====
`default_nettype none

module uasp_evtq #(
  parameter int QUEUE_DEPTH = uasp_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                push,
  input  wire uasp_pkg::uasp_evt_t push_data,
  input  wire logic                pop,
  output logic                     full,
  output logic                     head_valid,
  output uasp_pkg::uasp_evt_t      head_data
);
  import uasp_pkg::*;

  localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  uasp_evt_t       slot_r [QUEUE_DEPTH];
  logic [PW-1:0]   wr_ptr_r, rd_ptr_r;
  logic [CW-1:0]   count_r;
  logic            do_push, do_pop;

  assign full       = (count_r == CW'(QUEUE_DEPTH));
  assign head_valid = (count_r != '0);
  assign head_data  = slot_r[rd_ptr_r];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  function automatic logic [PW-1:0] wrap_inc(input logic [PW-1:0] p);
    return (p == PW'(QUEUE_DEPTH - 1)) ? '0 : p + PW'(1);
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wrap_inc(wr_ptr_r);
      end
      if (do_pop) begin
        rd_ptr_r <= wrap_inc(rd_ptr_r);
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + CW'(1);
      end else if (do_pop && !do_push) begin
        count_r <= count_r - CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

`default_nettype wire

// ===== design/uasp_capture.sv =====
`default_nettype none

module uasp_capture #(
  parameter int MAX_STREAMS = uasp_pkg::MAX_STREAMS_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                head_valid,
  input  wire uasp_pkg::uasp_evt_t evt,
  output logic                     pop,
  uasp_out_if.source               out_bus
);
  import uasp_pkg::*;

  logic [N_OPS-1:0] done_r;
  logic             open_r;
  logic [7:0]       alt_r, chan_r, bits_r, ep_r, ival_r;
  logic [23:0]      rate_r;
  logic [10:0]      pkt_r;
  logic [3:0]       count_r;

  logic             out_valid_r;
  logic             kind_r;
  logic [2:0]       index_r;
  logic [7:0]       o_alt_r, o_chan_r, o_bits_r, o_ep_r, o_ival_r;
  logic [23:0]      o_rate_r;
  logic [10:0]      o_pkt_r;
  logic [3:0]       o_total_r;
  logic             o_mal_r, o_last_r;

  logic [N_OPS-1:0] pending, sel, remaining;
  logic             step, close_active, emit_stream, emit, open_new, update_open;
  logic [3:0]       count_inc;

  assign pending = evt.ops & ~done_r;

  // Operations of one event run in order: descriptor finish, close, summary.
  always_comb begin
    sel = '0;
    priority if (pending[OP_FIN]) begin
      sel[OP_FIN] = 1'b1;
    end else if (pending[OP_CLOSE]) begin
      sel[OP_CLOSE] = 1'b1;
    end else if (pending[OP_SUM]) begin
      sel[OP_SUM] = 1'b1;
    end
  end

  assign remaining    = pending & ~sel;
  assign step         = head_valid && (!out_valid_r || out_bus.ready);
  assign pop          = step && (remaining == '0);
  assign close_active = open_r && (sel[OP_CLOSE] || (sel[OP_FIN] && evt.is_iface));
  assign emit_stream  = close_active && (ep_r != 8'd0);
  assign emit         = emit_stream || sel[OP_SUM];
  assign count_inc    = count_r + 4'(emit_stream);
  assign open_new     = sel[OP_FIN] && evt.is_iface && evt.iface_match &&
                        (count_inc < 4'(MAX_STREAMS));
  assign update_open  = sel[OP_FIN] && !evt.is_iface && open_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      done_r  <= '0;
      open_r  <= 1'b0;
      alt_r   <= 8'd0;
      chan_r  <= 8'd0;
      bits_r  <= 8'd0;
      rate_r  <= 24'd0;
      ep_r    <= 8'd0;
      pkt_r   <= 11'd0;
      ival_r  <= 8'd0;
      count_r <= 4'd0;
    end else if (step) begin
      done_r <= (remaining == '0) ? '0 : (done_r | sel);
      if (sel[OP_SUM]) begin
        open_r  <= 1'b0;
        alt_r   <= 8'd0;
        chan_r  <= 8'd0;
        bits_r  <= 8'd0;
        rate_r  <= 24'd0;
        ep_r    <= 8'd0;
        pkt_r   <= 11'd0;
        ival_r  <= 8'd0;
        count_r <= 4'd0;
      end else begin
        if (close_active) begin
          open_r  <= 1'b0;
          count_r <= count_inc;
        end
        if (open_new) begin
          open_r <= 1'b1;
          alt_r  <= evt.val_a;
          chan_r <= 8'd0;
          bits_r <= 8'd0;
          rate_r <= 24'd0;
          ep_r   <= 8'd0;
          pkt_r  <= 11'd0;
          ival_r <= 8'd0;
        end
        if (update_open && evt.is_fmt) begin
          chan_r <= evt.val_a;
          bits_r <= evt.val_b;
          if (evt.has_rate) begin
            rate_r <= evt.rate;
          end
        end
        if (update_open && evt.is_ep) begin
          ep_r   <= evt.val_a;
          pkt_r  <= evt.packet;
          ival_r <= evt.val_b;
        end
      end
    end
  end

  // Output register: the next beat is loaded while the current one is taken.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (step) begin
      out_valid_r <= emit;
    end else if (out_bus.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step && emit) begin
      kind_r    <= sel[OP_SUM] ? RECORD_SUMMARY : RECORD_STREAM;
      index_r   <= sel[OP_SUM] ? 3'd0 : count_r[2:0];
      o_alt_r   <= sel[OP_SUM] ? 8'd0 : alt_r;
      o_chan_r  <= sel[OP_SUM] ? 8'd0 : chan_r;
      o_bits_r  <= sel[OP_SUM] ? 8'd0 : bits_r;
      o_rate_r  <= sel[OP_SUM] ? 24'd0 : rate_r;
      o_ep_r    <= sel[OP_SUM] ? 8'd0 : ep_r;
      o_pkt_r   <= sel[OP_SUM] ? 11'd0 : pkt_r;
      o_ival_r  <= sel[OP_SUM] ? 8'd0 : ival_r;
      o_total_r <= sel[OP_SUM] ? count_r : count_inc;
      o_mal_r   <= evt.halted;
      o_last_r  <= sel[OP_SUM] || !evt.ops[OP_SUM];
    end
  end

  assign out_bus.valid            = out_valid_r;
  assign out_bus.record_kind      = kind_r;
  assign out_bus.stream_index     = index_r;
  assign out_bus.alt_setting      = o_alt_r;
  assign out_bus.channel_count    = o_chan_r;
  assign out_bus.sample_bits      = o_bits_r;
  assign out_bus.sample_rate      = o_rate_r;
  assign out_bus.endpoint_address = o_ep_r;
  assign out_bus.max_packet       = o_pkt_r;
  assign out_bus.poll_interval    = o_ival_r;
  assign out_bus.stream_total     = o_total_r;
  assign out_bus.malformed_seen   = o_mal_r;
  assign out_bus.last_result      = o_last_r;

endmodule

`default_nettype wire

// ===== design/usb_audio_stream_descriptor_parser.sv =====
// Throughput: one descriptor byte per cycle while the event queue has room; the final byte
// of a buffer occupies the back end for up to three steps (descriptor finish, capture close,
// summary), absorbed by the QUEUE_DEPTH-entry event queue between framer and capture logic.
// Path: with the back end idle, a byte's first result is registered in the event queue and
// then in the capture output register; a summary behind a finish and a close follows them.
// Reset: synchronous, active low; clears framing, capture, stream count, queue and the
// target interface register directly, with no clearing pass.
`default_nettype none

module usb_audio_stream_descriptor_parser #(
  parameter int MAX_STREAMS = uasp_pkg::MAX_STREAMS_DEF,
  parameter int QUEUE_DEPTH = uasp_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  uasp_in_if.sink    in_bus,
  uasp_out_if.source out_bus,
  uasp_cfg_if.sink   cfg_bus
);
  import uasp_pkg::*;

  uasp_evt_t evt_in, evt_head;
  uasp_qwr_t q_wr;
  uasp_qrd_t q_rd;

  uasp_framer u_framer (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_bus   (in_bus),
    .cfg_bus  (cfg_bus),
    .q_full   (q_wr.full),
    .evt_push (q_wr.push),
    .evt_data (evt_in)
  );

  uasp_evtq #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_evtq (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_wr.push),
    .push_data  (evt_in),
    .pop        (q_rd.pop),
    .full       (q_wr.full),
    .head_valid (q_rd.head_valid),
    .head_data  (evt_head)
  );

  uasp_capture #(
    .MAX_STREAMS (MAX_STREAMS)
  ) u_capture (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (q_rd.head_valid),
    .evt        (evt_head),
    .pop        (q_rd.pop),
    .out_bus    (out_bus)
  );

  a_summary_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_bus.valid && out_bus.record_kind == RECORD_SUMMARY) |-> out_bus.last_result)
    else $error("summary beat without last_result");

  a_stream_has_endpoint: assert property (@(posedge clk) disable iff (!rst_n)
    (out_bus.valid && out_bus.record_kind == RECORD_STREAM) |->
      (out_bus.endpoint_address != 8'd0 && out_bus.stream_total <= 4'(MAX_STREAMS)))
    else $error("stream beat with zero endpoint or count beyond limit");

  a_count_restarts: assert property (@(posedge clk) disable iff (!rst_n)
    (out_bus.valid && out_bus.ready && out_bus.record_kind == RECORD_SUMMARY) |=>
      !(out_bus.valid && out_bus.record_kind == RECORD_STREAM &&
        out_bus.stream_index != 3'd0))
    else $error("stream slot not restarted after summary");

endmodule

`default_nettype wire
